/* hw/rtl/printer_rle_byte_encoder_macros.svh */
// assertion macros used by the checker file
`ifndef PRINTER_RLE_BYTE_ENCODER_MACROS_SVH
`define PRINTER_RLE_BYTE_ENCODER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define PRLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define PRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/prle_pkg.sv */
package prle_pkg;

   // literal buffer and run limits
   localparam int LIT_MAX = 60;
   localparam int RUN_MAX = 129;

   localparam int LIT_CW  = $clog2(LIT_MAX + 1);
   localparam int LIT_AW  = $clog2(LIT_MAX);
   localparam int HELD_CW = $clog2(RUN_MAX + 1);

   typedef logic [LIT_CW-1:0]  lit_cnt_type;
   typedef logic [LIT_AW-1:0]  lit_addr_type;
   typedef logic [HELD_CW-1:0] held_cnt_type;

   // top bit of a header marks a run
   localparam logic RUN_FLAG = 1'b1;
   localparam logic LIT_FLAG = 1'b0;

   // sequencer to output stage
   typedef struct packed {
      logic       emit;
      logic [7:0] emit_byte;
      logic       close;
      logic       close_fin;
   } out_req_type;

   // output stage to sequencer
   typedef struct packed {
      logic room;
      logic pend_vld;
   } out_sts_type;

   // literal store access
   typedef struct packed {
      logic         wr_en;
      lit_addr_type wr_addr;
      logic [7:0]   wr_data;
      lit_addr_type rd_addr;
   } mem_req_type;

endpackage

/* hw/rtl/prle_lit_mem.sv */
module prle_lit_mem (
   input  logic                  clock,
   input  prle_pkg::mem_req_type mem_req,
   output logic [7:0]            rd_data
);

   logic [7:0] store_ff [prle_pkg::LIT_MAX];
   logic [7:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= store_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/prle_out.sv */
module prle_out (
   input  logic                  clock,
   input  logic                  reset,
   input  prle_pkg::out_req_type out_req,
   output prle_pkg::out_sts_type out_sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_of_burst,
   output logic                  rsp_end_of_stream
);

   logic       pend_vld_ff, pend_vld_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_eos_ff, rsp_eos_in;
   logic       out_free;
   logic       load;

   // a word is held back one step so the last of a burst can be flagged
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = pend_vld_ff && (out_req.emit || out_req.close);

   assign out_sts.room     = !pend_vld_ff || out_free;
   assign out_sts.pend_vld = pend_vld_ff;

   // next values of the held word and the output register
   always_comb begin
      pend_vld_in  = pend_vld_ff;
      pend_byte_in = pend_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eos_in   = rsp_eos_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = pend_byte_ff;
         rsp_last_in  = out_req.close;
         rsp_eos_in   = out_req.close && out_req.close_fin;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_req.emit) begin
         pend_vld_in  = 1'b1;
         pend_byte_in = out_req.emit_byte;
      end else if (out_req.close) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_byte_ff <= pend_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_eos_ff   <= rsp_eos_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_burst = rsp_last_ff;
   assign rsp_end_of_stream = rsp_eos_ff;

endmodule

/* hw/rtl/prle_seq.sv */
module prle_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_final_byte,
   input  prle_pkg::out_sts_type out_sts,
   output prle_pkg::out_req_type out_req,
   output prle_pkg::mem_req_type mem_req,
   input  logic [7:0]            rd_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MATCH   = 4'd1;
   localparam logic [3:0] ST_RUNCHK  = 4'd2;
   localparam logic [3:0] ST_RETIRE  = 4'd3;
   localparam logic [3:0] ST_NEW     = 4'd4;
   localparam logic [3:0] ST_FIN     = 4'd5;
   localparam logic [3:0] ST_FRUN    = 4'd6;
   localparam logic [3:0] ST_DONE    = 4'd7;
   localparam logic [3:0] ST_FL_HDR  = 4'd8;
   localparam logic [3:0] ST_FL_DATA = 4'd9;
   localparam logic [3:0] ST_RN_HDR  = 4'd10;
   localparam logic [3:0] ST_RN_DATA = 4'd11;

   logic [3:0]             state_ff, state_in;
   logic [3:0]             ret_ff, ret_in;
   prle_pkg::held_cnt_type held_ff, held_in;
   logic [7:0]             hbyte_ff, hbyte_in;
   prle_pkg::lit_cnt_type  lit_ff, lit_in;
   prle_pkg::lit_addr_type idx_ff, idx_in;
   logic [7:0]             b_ff, b_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             end_next;
   logic                   lit_full;
   logic                   idx_last;
   logic                   run_done;

   assign req_stall = (state_ff != ST_IDLE);

   // where an item goes once its own step is over
   assign end_next = fin_ff ? ST_FIN : (out_sts.pend_vld ? ST_DONE : ST_IDLE);

   assign lit_full = (lit_ff + prle_pkg::lit_cnt_type'(1))
                     == prle_pkg::lit_cnt_type'(prle_pkg::LIT_MAX);
   assign idx_last = prle_pkg::lit_cnt_type'(idx_ff)
                     == (lit_ff - prle_pkg::lit_cnt_type'(1));
   assign run_done = held_ff >= prle_pkg::held_cnt_type'(prle_pkg::RUN_MAX);

   // step sequencer with literal flush and run send as shared sub-sequences
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      held_in  = held_ff;
      hbyte_in = hbyte_ff;
      lit_in   = lit_ff;
      idx_in   = idx_ff;
      b_in     = b_ff;
      fin_in   = fin_ff;
      out_req  = '0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = lit_ff[prle_pkg::LIT_AW-1:0];
      mem_req.wr_data = hbyte_ff;
      mem_req.rd_addr = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               b_in   = req_data_byte;
               fin_in = req_final_byte;
               if (held_ff != '0 && req_data_byte == hbyte_ff) begin
                  held_in  = held_ff + prle_pkg::held_cnt_type'(1);
                  state_in = ST_MATCH;
               end else begin
                  state_in = ST_RETIRE;
               end
            end
         end
         // second copy starts a run: literal goes out first
         ST_MATCH: begin
            if (held_ff == prle_pkg::held_cnt_type'(2) && lit_ff != '0) begin
               ret_in   = ST_RUNCHK;
               state_in = ST_FL_HDR;
            end else begin
               state_in = ST_RUNCHK;
            end
         end
         ST_RUNCHK: begin
            if (run_done) begin
               ret_in   = ST_FIN;
               state_in = ST_RN_HDR;
            end else begin
               state_in = end_next;
            end
         end
         // byte differs: send the run, or move a single byte to the literal, then hold the new byte
         ST_RETIRE: begin
            if (held_ff >= prle_pkg::held_cnt_type'(2)) begin
               ret_in   = ST_NEW;
               state_in = ST_RN_HDR;
            end else if (held_ff == prle_pkg::held_cnt_type'(1)) begin
               mem_req.wr_en = 1'b1;
               lit_in        = lit_ff + prle_pkg::lit_cnt_type'(1);
               if (lit_full) begin
                  held_in  = '0;
                  ret_in   = ST_NEW;
                  state_in = ST_FL_HDR;
               end else begin
                  hbyte_in = b_ff;
                  held_in  = prle_pkg::held_cnt_type'(1);
                  state_in = end_next;
               end
            end else begin
               hbyte_in = b_ff;
               held_in  = prle_pkg::held_cnt_type'(1);
               state_in = end_next;
            end
         end
         ST_NEW: begin
            hbyte_in = b_ff;
            held_in  = prle_pkg::held_cnt_type'(1);
            state_in = end_next;
         end
         // last byte: drain literal, then run; a lone held byte joins the literal first
         ST_FIN: begin
            if (!fin_ff) begin
               state_in = out_sts.pend_vld ? ST_DONE : ST_IDLE;
            end else if (held_ff >= prle_pkg::held_cnt_type'(2)) begin
               ret_in   = ST_FRUN;
               state_in = ST_FL_HDR;
            end else if (held_ff == prle_pkg::held_cnt_type'(1)) begin
               mem_req.wr_en = 1'b1;
               lit_in        = lit_ff + prle_pkg::lit_cnt_type'(1);
               held_in       = '0;
               ret_in        = ST_DONE;
               state_in      = ST_FL_HDR;
            end else begin
               ret_in   = ST_DONE;
               state_in = ST_FL_HDR;
            end
         end
         ST_FRUN: begin
            ret_in   = ST_DONE;
            state_in = ST_RN_HDR;
         end
         // flag the held word as last of the burst, clear state after the image
         ST_DONE: begin
            if (out_sts.room) begin
               out_req.close     = 1'b1;
               out_req.close_fin = fin_ff;
               if (fin_ff) begin
                  held_in  = '0;
                  hbyte_in = '0;
                  lit_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FL_HDR: begin
            mem_req.rd_addr = '0;
            if (lit_ff == '0) begin
               state_in = ret_ff;
            end else if (out_sts.room) begin
               out_req.emit      = 1'b1;
               out_req.emit_byte = {prle_pkg::LIT_FLAG,
                                    7'(lit_ff - prle_pkg::lit_cnt_type'(1))};
               idx_in   = '0;
               state_in = ST_FL_DATA;
            end
         end
         // one stored byte per cycle while the output has room, next address read ahead
         ST_FL_DATA: begin
            if (out_sts.room) begin
               out_req.emit      = 1'b1;
               out_req.emit_byte = rd_data;
               if (idx_last) begin
                  lit_in   = '0;
                  state_in = ret_ff;
               end else begin
                  idx_in          = idx_ff + prle_pkg::lit_addr_type'(1);
                  mem_req.rd_addr = idx_ff + prle_pkg::lit_addr_type'(1);
               end
            end
         end
         ST_RN_HDR: begin
            if (out_sts.room) begin
               out_req.emit      = 1'b1;
               out_req.emit_byte = {prle_pkg::RUN_FLAG,
                                    7'(held_ff - prle_pkg::held_cnt_type'(2))};
               state_in = ST_RN_DATA;
            end
         end
         ST_RN_DATA: begin
            if (out_sts.room) begin
               out_req.emit      = 1'b1;
               out_req.emit_byte = hbyte_ff;
               held_in           = '0;
               state_in          = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         held_ff  <= '0;
         hbyte_ff <= '0;
         lit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         held_ff  <= held_in;
         hbyte_ff <= hbyte_in;
         lit_ff   <= lit_in;
      end
      idx_ff <= idx_in;
      b_ff   <= b_in;
      fin_ff <= fin_in;
   end

endmodule

/* hw/rtl/printer_rle_byte_encoder.sv */
// channel   | valid      | stall      | payload
// ----------+------------+------------+-------------------------------------------------
// input     | req_valid  | req_stall  | req_data_byte, req_final_byte
// result    | rsp_valid  | rsp_stall  | rsp_out_byte, rsp_last_of_burst, rsp_end_of_stream
//
// a differing byte steps through accept and retire, an equal one through accept, match and
// run check; a step that made words then closes its burst, a reload of the held byte follows
// a sent run or full literal, a run at its limit passes the last-byte step, and the last
// byte of an image passes it to choose what to drain; a run is sent as a header and its byte
// a literal flush sends a header, then one stored word per cycle while the output has room
// reset clears sequencer and counters; the literal store is not cleared
// rsp_stall holds the sequencer only while a word is waiting to move out

module printer_rle_byte_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_burst,
   output logic       rsp_end_of_stream
);

   prle_pkg::out_req_type out_req;
   prle_pkg::out_sts_type out_sts;
   prle_pkg::mem_req_type mem_req;
   logic [7:0]            rd_data;

   // control and run/literal bookkeeping
   prle_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .out_sts        (out_sts),
      .out_req        (out_req),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   // pending literal bytes
   prle_lit_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // held word and output register
   prle_out u_out (
      .clock             (clock),
      .reset             (reset),
      .out_req           (out_req),
      .out_sts           (out_sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

endmodule

/* hw/rtl/prle_checker.sv */
`include "printer_rle_byte_encoder_macros.svh"

module prle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_stream,
   input logic       rsp_last_of_burst
);

   // end of image always closes a burst
   `PRLE_ASSERT_NOW(a_eos_is_last, clock, reset, rsp_valid && rsp_end_of_stream, rsp_last_of_burst, "end of stream without last of burst")

   // an accepted byte keeps the input closed in the cycle after it
   `PRLE_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_valid && !req_stall, req_stall, "input open right after accept")

   // a stalled result word holds
   `PRLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte), "stalled result word changed")

endmodule

bind printer_rle_byte_encoder prle_checker u_prle_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_end_of_stream (rsp_end_of_stream),
   .rsp_last_of_burst (rsp_last_of_burst)
);

/* verif/tb_printer_rle_byte_encoder.sv */
`timescale 1ns / 1ps

module tb_printer_rle_byte_encoder;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_WORDS = 80;
   localparam int DRAIN_CYCLES = 20;

   // one compressed output word as the encoder should produce it
   typedef struct packed {
      logic [7:0] data;
      logic       burst_end;
      logic       image_end;
   } coded_word_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte  = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_burst;
   logic       rsp_end_of_stream;

   printer_rle_byte_encoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   always #2 clock = ~clock;

   // mirror of the encoder state
   logic [7:0]  lit_bytes [prle_pkg::LIT_MAX];
   int unsigned lit_len  = 0;
   logic [7:0]  run_byte = 8'h00;
   int unsigned run_len  = 0;

   coded_word_type step_words [$];
   coded_word_type coded_queue [$];

   int unsigned words_in    = 0;
   int unsigned words_out   = 0;
   int unsigned images_sent = 0;
   int unsigned fails       = 0;
   int unsigned idle_cycles = 0;
   logic [7:0]  last_sent   = 8'h00;

   // idling control
   bit          calm          = 1'b0;
   int unsigned send_gap_odds = 4;
   int unsigned hold_asked    = 0;
   int unsigned hold_taken    = 0;
   int unsigned hold_left     = 0;
   int unsigned stall_left    = 0;
   int unsigned free_left     = 0;

   function automatic void put_coded(logic [7:0] b);
      coded_word_type w;
      w.data      = b;
      w.burst_end = 1'b0;
      w.image_end = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void flush_literal();
      if (lit_len == 0) return;
      put_coded({prle_pkg::LIT_FLAG, 7'(lit_len - 1)});
      for (int unsigned i = 0; i < lit_len; i++) put_coded(lit_bytes[i]);
      lit_len = 0;
   endfunction

   // a byte joins the literal; a full literal goes out at once
   function automatic void add_literal(logic [7:0] b);
      if (lit_len < prle_pkg::LIT_MAX) begin
         lit_bytes[lit_len] = b;
         lit_len++;
      end
      if (lit_len >= prle_pkg::LIT_MAX) flush_literal();
   endfunction

   function automatic void send_run();
      put_coded({prle_pkg::RUN_FLAG, 7'(run_len - 2)});
      put_coded(run_byte);
      run_len = 0;
   endfunction

   function automatic void retire_candidate();
      if (run_len >= 2) begin
         send_run();
      end else if (run_len == 1) begin
         add_literal(run_byte);
         run_len = 0;
      end
   endfunction

   // compressed words caused by one image byte, appended to the expected queue
   function automatic void encode_byte(logic [7:0] b, logic fin);
      coded_word_type w;
      step_words.delete();
      if (run_len != 0 && b == run_byte) begin
         run_len++;
         if (run_len == 2) flush_literal();
         if (run_len >= prle_pkg::RUN_MAX) send_run();
      end else begin
         retire_candidate();
         run_byte = b;
         run_len  = 1;
      end
      // end of image: literal first, then the run; a lone byte joins the literal
      if (fin) begin
         if (run_len >= 2) begin
            flush_literal();
            send_run();
         end else begin
            retire_candidate();
            flush_literal();
         end
         run_byte = 8'h00;
         run_len  = 0;
         lit_len  = 0;
      end
      if (step_words.size() > 0) begin
         w           = step_words.pop_back();
         w.burst_end = 1'b1;
         w.image_end = fin;
         step_words.push_back(w);
      end
      foreach (step_words[i]) coded_queue.push_back(step_words[i]);
   endfunction

   // offer one word, with an occasional gap ahead of it
   task automatic send_word(input logic [7:0] b, input logic fin);
      if (!calm && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      encode_byte(b, fin);
      last_sent = b;
      words_in++;
      if (fin) images_sent++;
   endtask

   task automatic send_run_of(input logic [7:0] b, input int unsigned n, input logic fin);
      for (int unsigned i = 0; i < n; i++) send_word(b, fin && (i == n - 1));
   endtask

   // each byte differs from the one before it
   task automatic send_literal_of(input int unsigned n, input logic fin);
      for (int unsigned i = 0; i < n; i++)
         send_word(last_sent + 8'($urandom_range(1, 255)), fin && (i == n - 1));
   endtask

   task automatic test_short_images();
      send_gap_odds = 4;
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_run_of(8'hFF, 2, 1'b1);
      // literal flushed ahead of the run that follows it
      send_word(8'h12, 1'b0);
      send_word(8'h34, 1'b0);
      send_run_of(8'h56, 3, 1'b1);
      // run closed by a lone last byte
      send_run_of(8'h07, 3, 1'b0);
      send_word(8'h09, 1'b1);
      // lone bytes on both sides of a short run
      send_word(8'h01, 1'b0);
      send_run_of(8'h02, 2, 1'b0);
      send_word(8'h03, 1'b0);
      send_word(8'h04, 1'b1);
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b1);
      send_word(8'h80, 1'b0);
      send_word(8'h7F, 1'b1);
   endtask

   task automatic test_run_limit();
      send_gap_odds = 6;
      // full run, then the next equal bytes start a new candidate
      send_run_of(8'hAA, prle_pkg::RUN_MAX + 2, 1'b1);
   endtask

   task automatic test_literal_full();
      send_gap_odds = 5;
      // literal fills when a lone byte joins it, then a run of two ends the image
      send_literal_of(prle_pkg::LIT_MAX + 1, 1'b0);
      send_word(last_sent, 1'b1);
   endtask

   task automatic test_output_backpressure();
      send_gap_odds = 0;
      hold_asked++;
      send_literal_of(10, 1'b0);
      send_run_of(last_sent + 8'h01, 6, 1'b0);
      send_literal_of(8, 1'b1);
   endtask

   task automatic random_image();
      int unsigned segs;
      int unsigned len;
      logic        fin;
      logic [7:0]  base;
      segs = $urandom_range(1, 6);
      if ($urandom_range(0, 4) == 0) begin
         // noise: a tiny alphabet mixes runs and lone bytes, stray last flags
         base = 8'($urandom);
         len  = segs * 3;
         for (int unsigned i = 0; i < len; i++) begin
            fin = (i == len - 1) || ($urandom_range(0, 7) == 0);
            send_word(base + 8'($urandom_range(0, 2)), fin);
         end
      end else begin
         for (int unsigned s = 0; s < segs; s++) begin
            fin = (s == segs - 1);
            if ($urandom_range(0, 1) == 1) begin
               len = ($urandom_range(0, 15) == 0) ?
                     $urandom_range(prle_pkg::RUN_MAX - 4, prle_pkg::RUN_MAX + 8) :
                     $urandom_range(2, 6);
               send_run_of(last_sent + 8'($urandom_range(1, 255)), len, fin);
            end else begin
               len = ($urandom_range(0, 15) == 0) ?
                     $urandom_range(prle_pkg::LIT_MAX - 3, prle_pkg::LIT_MAX + 6) :
                     $urandom_range(1, 12);
               send_literal_of(len, fin);
            end
         end
      end
   endtask

   task automatic test_random_images();
      int unsigned start;
      start = words_in;
      while (words_in - start < RANDOM_WORDS) begin
         calm          = (words_in - start) > (RANDOM_WORDS * 4) / 5;
         send_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         random_image();
      end
   endtask

   // receiver stall: a long hold on request, none while calm, else random bursts and free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && free_left == 0) begin
            if ($urandom_range(0, 2) == 0)
               stall_left = $urandom_range(1, 19);
            else
               free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                       : $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            free_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each compressed word with the oldest expected one
   always @(posedge clock) begin
      coded_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (coded_queue.size() == 0) begin
            $error("compressed word %0h arrived with nothing expected", rsp_out_byte);
            fails++;
         end else begin
            want = coded_queue.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte expected %0h got %0h", want.data, rsp_out_byte);
               fails++;
            end
            if (rsp_last_of_burst !== want.burst_end) begin
               $error("last_of_burst expected %0b got %0b", want.burst_end,
                      rsp_last_of_burst);
               fails++;
            end
            if (rsp_end_of_stream !== want.image_end) begin
               $error("end_of_stream expected %0b got %0b", want.image_end,
                      rsp_end_of_stream);
               fails++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_images();
      test_run_limit();
      test_literal_full();
      test_output_backpressure();
      test_random_images();
      req_valid <= 1'b0;
      while (coded_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d image bytes in %0d images, %0d compressed words checked",
               words_in, images_sent, words_out);
      $display("covered runs at the length limit, full literals and a long output hold");
      if (fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
